// ----- hw/rtl/tribc_pkg.sv -----
`default_nettype none
package tribc_pkg;
	localparam int CB = 12;
	localparam int FB = 16;
	localparam int DB = CB + 1;
	localparam int PB = 2 * DB;
	localparam int CPB = PB + 1;
	localparam int NB = 2 * CPB + 2;
	localparam int LB = NB / 2;
	localparam int QB = LB + FB;
	localparam int WB = FB + 1;

	localparam logic [1:0] REG_V0 = 2'd0;
	localparam logic [1:0] REG_V1 = 2'd1;
	localparam logic [1:0] REG_V2 = 2'd2;
	localparam logic [1:0] REG_TOL = 2'd3;

	typedef struct packed {
		logic signed [CB-1:0] point_z;
		logic signed [CB-1:0] point_y;
		logic signed [CB-1:0] point_x;
	} in_t;

	typedef struct packed {
		logic [WB-1:0] weight_v0;
		logic [WB-1:0] weight_v1;
		logic [WB-1:0] weight_v2;
		logic inside_res;
		logic degenerate;
	} out_t;

	typedef struct packed {
		logic signed [DB-1:0] x;
		logic signed [DB-1:0] y;
		logic signed [DB-1:0] z;
	} dvec_t;

	typedef logic [LB-1:0] len3_t [3];
endpackage
`default_nettype wire

// ----- hw/rtl/tribc_sqrt_cell.sv -----
`default_nettype none
// One result bit of a restoring integer square root per cell.
module tribc_sqrt_cell (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [4:0]                bitpos,
	input  wire logic [tribc_pkg::NB-1:0]  rem_i [4],
	input  wire logic [tribc_pkg::LB-1:0]  root_i [4],
	output logic [tribc_pkg::NB-1:0]       rem_o [4],
	output logic [tribc_pkg::LB-1:0]       root_o [4]
);
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				logic [tribc_pkg::NB+1:0] trial;
				trial = {2'b00, rem_i[k]} -
					(({{(tribc_pkg::NB+2-tribc_pkg::LB){1'b0}}, root_i[k]} << (bitpos + 5'd1))
					| ({{(tribc_pkg::NB+1){1'b0}}, 1'b1} << (2 * bitpos)));
				if (!trial[tribc_pkg::NB+1]) begin
					rem_o[k]  <= trial[tribc_pkg::NB-1:0];
					root_o[k] <= root_i[k] | (tribc_pkg::LB'(1) << bitpos);
				end else begin
					rem_o[k]  <= rem_i[k];
					root_o[k] <= root_i[k];
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/tribc_div_cell.sv -----
`default_nettype none
// One quotient bit of a restoring divider per cell, three lanes.
module tribc_div_cell (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [4:0]                bitpos,
	input  wire logic [tribc_pkg::LB-1:0]  den,
	input  wire logic [tribc_pkg::QB-1:0]  rem_i [3],
	input  wire logic [tribc_pkg::WB:0]    quo_i [3],
	output logic [tribc_pkg::QB-1:0]       rem_o [3],
	output logic [tribc_pkg::WB:0]         quo_o [3]
);
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic [tribc_pkg::QB+tribc_pkg::WB:0] sh;
				sh = {{(tribc_pkg::QB+tribc_pkg::WB+1-tribc_pkg::LB){1'b0}}, den} << bitpos;
				if ({{(tribc_pkg::WB+1){1'b0}}, rem_i[k]} >= sh) begin
					rem_o[k] <= rem_i[k] - sh[tribc_pkg::QB-1:0];
					quo_o[k] <= quo_i[k] | ((tribc_pkg::WB+1)'(1) << bitpos);
				end else begin
					rem_o[k] <= rem_i[k];
					quo_o[k] <= quo_i[k];
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/triangle_barycentric_test_top.sv -----
`default_nettype none
// Pipeline from input transaction to result register: product and length stages,
// 28 root cells, 18 divide cells and the output register.
// Throughput: one transaction per cycle; the chain of root and divide cells advances
// every cycle a transaction moves and holds as a whole on output stall.
// Reset: arst_n clears all valid bits; vertices to 0, tolerance to 4.
module triangle_barycentric_test_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tribc_pkg::in_t      in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tribc_pkg::out_t          out_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [35:0]         cfg_wdata
);
	localparam int NR = tribc_pkg::LB;
	localparam int ND = tribc_pkg::WB + 1;
	localparam int NS = 4 + NR + ND;

	logic [35:0] v_q [3];
	logic [7:0]  tol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= '0; v_q[1] <= '0; v_q[2] <= '0;
			tol_q <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tribc_pkg::REG_V0:  v_q[0] <= cfg_wdata;
				tribc_pkg::REG_V1:  v_q[1] <= cfg_wdata;
				tribc_pkg::REG_V2:  v_q[2] <= cfg_wdata;
				tribc_pkg::REG_TOL: tol_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic [NS-1:0] vld_q;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
			out_valid <= vld_q[NS-1];
		end
	end

	function automatic tribc_pkg::dvec_t dsub(input logic [35:0] a, input logic [35:0] b);
		tribc_pkg::dvec_t r;
		r.x = tribc_pkg::DB'($signed(a[11:0])) - tribc_pkg::DB'($signed(b[11:0]));
		r.y = tribc_pkg::DB'($signed(a[23:12])) - tribc_pkg::DB'($signed(b[23:12]));
		r.z = tribc_pkg::DB'($signed(a[35:24])) - tribc_pkg::DB'($signed(b[35:24]));
		return r;
	endfunction

	// stage 1: edge vectors
	tribc_pkg::dvec_t a_s1 [4], b_s1 [4];
	logic [35:0] p;
	assign p = {in_data.point_z, in_data.point_y, in_data.point_x};
	always_ff @(posedge clk) if (adv) begin
		a_s1[0] <= dsub(v_q[1], v_q[0]); b_s1[0] <= dsub(v_q[2], v_q[0]);
		a_s1[1] <= dsub(v_q[1], p);      b_s1[1] <= dsub(v_q[2], p);
		a_s1[2] <= dsub(p, v_q[0]);      b_s1[2] <= dsub(v_q[2], v_q[0]);
		a_s1[3] <= dsub(v_q[1], v_q[0]); b_s1[3] <= dsub(p, v_q[0]);
	end

	// stage 2: products, stage 3: cross components magnitude
	logic signed [tribc_pkg::PB-1:0] pr_s2 [4][6];
	logic [tribc_pkg::CPB-1:0] c_s3 [4][3];
	always_ff @(posedge clk) if (adv) begin
		for (int k = 0; k < 4; k++) begin
			pr_s2[k][0] <= tribc_pkg::PB'(a_s1[k].y) * tribc_pkg::PB'(b_s1[k].z);
			pr_s2[k][1] <= tribc_pkg::PB'(a_s1[k].z) * tribc_pkg::PB'(b_s1[k].y);
			pr_s2[k][2] <= tribc_pkg::PB'(a_s1[k].z) * tribc_pkg::PB'(b_s1[k].x);
			pr_s2[k][3] <= tribc_pkg::PB'(a_s1[k].x) * tribc_pkg::PB'(b_s1[k].z);
			pr_s2[k][4] <= tribc_pkg::PB'(a_s1[k].x) * tribc_pkg::PB'(b_s1[k].y);
			pr_s2[k][5] <= tribc_pkg::PB'(a_s1[k].y) * tribc_pkg::PB'(b_s1[k].x);
		end
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++) begin
				logic signed [tribc_pkg::CPB-1:0] d;
				d = tribc_pkg::CPB'(pr_s2[k][2*j]) - tribc_pkg::CPB'(pr_s2[k][2*j+1]);
				c_s3[k][j] <= d[tribc_pkg::CPB-1] ? tribc_pkg::CPB'(-d) : d;
			end
		end
	end

	// stage 4: squared length
	logic [tribc_pkg::NB-1:0] sq_s4 [4];
	always_ff @(posedge clk) if (adv) begin
		for (int k = 0; k < 4; k++)
			sq_s4[k] <= tribc_pkg::NB'(c_s3[k][0]) * tribc_pkg::NB'(c_s3[k][0])
				+ tribc_pkg::NB'(c_s3[k][1]) * tribc_pkg::NB'(c_s3[k][1])
				+ tribc_pkg::NB'(c_s3[k][2]) * tribc_pkg::NB'(c_s3[k][2]);
	end

	logic [tribc_pkg::NB-1:0] rrem [NR+1][4];
	logic [NR-1:0]            rroot [NR+1][4];
	logic [7:0]               rtol [NS+1];
	assign rrem[0] = sq_s4;
	for (genvar k = 0; k < 4; k++) begin : g_r0
		assign rroot[0][k] = '0;
	end
	for (genvar i = 0; i < NR; i++) begin : g_sq
		logic [NR-1:0] ri [4];
		logic [NR-1:0] ro [4];
		logic [tribc_pkg::NB-1:0] mi [4];
		logic [tribc_pkg::NB-1:0] mo [4];
		assign mi = rrem[i];
		assign ri = rroot[i];
		tribc_sqrt_cell u_cell (
			.clk(clk), .en(adv), .bitpos(5'(NR-1-i)),
			.rem_i(mi), .root_i(ri),
			.rem_o(mo), .root_o(ro)
		);
		assign rrem[i+1] = mo;
		assign rroot[i+1] = ro;
	end

	// tolerance travels with its transaction
	assign rtol[0] = tol_q;
	for (genvar i = 0; i < NS; i++) begin : g_tol
		logic [7:0] t_q;
		always_ff @(posedge clk) if (adv) t_q <= rtol[i];
		assign rtol[i+1] = t_q;
	end

	logic [tribc_pkg::QB-1:0] drem [ND+1][3];
	logic [ND-1:0]            dquo [ND+1][3];
	logic [NR-1:0]            dden [ND+1];
	assign dden[0] = rroot[NR][0];
	for (genvar k = 0; k < 3; k++) begin : g_d0
		assign drem[0][k] = {rroot[NR][k+1], {tribc_pkg::FB{1'b0}}};
		assign dquo[0][k] = '0;
	end
	for (genvar i = 0; i < ND; i++) begin : g_dv
		logic [tribc_pkg::QB-1:0] mi [3];
		logic [tribc_pkg::QB-1:0] mo [3];
		logic [ND-1:0] qi [3];
		logic [ND-1:0] qo [3];
		logic [NR-1:0] den_q;
		assign mi = drem[i];
		assign qi = dquo[i];
		always_ff @(posedge clk) if (adv) den_q <= dden[i];
		tribc_div_cell u_cell (
			.clk(clk), .en(adv), .bitpos(5'(ND-1-i)), .den(dden[i]),
			.rem_i(mi), .quo_i(qi),
			.rem_o(mo), .quo_o(qo)
		);
		assign drem[i+1] = mo;
		assign dquo[i+1] = qo;
		assign dden[i+1] = den_q;
	end

	// final: saturate, classify. Quotient bit WB set means >= 2.0.
	logic [tribc_pkg::WB-1:0] w [3];
	logic [tribc_pkg::WB+1:0] wsum;
	logic all_le;
	always_comb begin
		for (int k = 0; k < 3; k++)
			w[k] = dquo[ND][k][ND-1] ? '1 : dquo[ND][k][tribc_pkg::WB-1:0];
		wsum = (tribc_pkg::WB+2)'(w[0]) + (tribc_pkg::WB+2)'(w[1]) + (tribc_pkg::WB+2)'(w[2]);
		all_le = (w[0] <= (tribc_pkg::WB)'(1 << tribc_pkg::FB))
			&& (w[1] <= (tribc_pkg::WB)'(1 << tribc_pkg::FB))
			&& (w[2] <= (tribc_pkg::WB)'(1 << tribc_pkg::FB));
	end

	always_ff @(posedge clk) if (adv) begin
		if (dden[ND] == '0) begin
			out_data <= '{weight_v0: '0, weight_v1: '0, weight_v2: '0,
				inside_res: 1'b0, degenerate: 1'b1};
		end else begin
			out_data.weight_v0 <= w[0];
			out_data.weight_v1 <= w[1];
			out_data.weight_v2 <= w[2];
			out_data.inside_res <= all_le && (wsum <=
				(tribc_pkg::WB+2)'(1 << tribc_pkg::FB) + (tribc_pkg::WB+2)'(rtol[NS]));
			out_data.degenerate <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/tribc_checker.sv -----
`default_nettype none
module tribc_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire tribc_pkg::out_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> !out_data.inside_res && out_data.weight_v0 == '0)
		else $error("degenerate");
	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_res |->
		out_data.weight_v0 <= 17'h10000 && out_data.weight_v1 <= 17'h10000
		&& out_data.weight_v2 <= 17'h10000) else $error("inside");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready");
endmodule
bind triangle_barycentric_test_top tribc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ----- sim/tb_triangle_barycentric_test_top.sv -----
`default_nettype none
module tb_triangle_barycentric_test_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tribc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tribc_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = tribc_pkg::REG_V0;
	logic [35:0] cfg_wdata = '0;

	triangle_barycentric_test_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	typedef struct {
		tribc_pkg::in_t pt;
		bit typed;
		tribc_pkg::out_t res;
	} row_t;

	// triangle copy for prediction
	int vx[3], vy[3], vz[3];
	int tol_q;
	tribc_pkg::out_t weights_q[$];
	bit failed = 1'b0;
	bit burst = 1'b0;

	function automatic longint unsigned area_len(int ax, int ay, int az, int bx, int by, int bz);
		longint cx, cy, cz;
		longint unsigned n, r, cand;
		cx = longint'(ay) * bz - longint'(az) * by;
		cy = longint'(az) * bx - longint'(ax) * bz;
		cz = longint'(ax) * by - longint'(ay) * bx;
		n = cx * cx + cy * cy + cz * cz;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= n)
				r = cand;
		end
		return r;
	endfunction

	function automatic longint unsigned to_weight(longint unsigned sub, longint unsigned full);
		longint unsigned q;
		q = (sub << tribc_pkg::FB) / full;
		return (q > 131071) ? 131071 : q;
	endfunction

	function automatic tribc_pkg::out_t predict_weights(tribc_pkg::in_t p);
		tribc_pkg::out_t o;
		int px, py, pz;
		longint unsigned full, w0, w1, w2;
		px = p.point_x; py = p.point_y; pz = p.point_z;
		o = '0;
		full = area_len(vx[1]-vx[0], vy[1]-vy[0], vz[1]-vz[0],
			vx[2]-vx[0], vy[2]-vy[0], vz[2]-vz[0]);
		if (full == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		w0 = to_weight(area_len(vx[1]-px, vy[1]-py, vz[1]-pz,
			vx[2]-px, vy[2]-py, vz[2]-pz), full);
		w1 = to_weight(area_len(px-vx[0], py-vy[0], pz-vz[0],
			vx[2]-vx[0], vy[2]-vy[0], vz[2]-vz[0]), full);
		w2 = to_weight(area_len(vx[1]-vx[0], vy[1]-vy[0], vz[1]-vz[0],
			px-vx[0], py-vy[0], pz-vz[0]), full);
		o.weight_v0 = w0[tribc_pkg::WB-1:0];
		o.weight_v1 = w1[tribc_pkg::WB-1:0];
		o.weight_v2 = w2[tribc_pkg::WB-1:0];
		o.inside_res = (w0 <= 65536) && (w1 <= 65536) && (w2 <= 65536) &&
			(w0 + w1 + w2 <= 65536 + tol_q);
		return o;
	endfunction

	function automatic int clamp(int v);
		return (v > 2047) ? 2047 : ((v < -2048) ? -2048 : v);
	endfunction

	function automatic tribc_pkg::in_t mk_pt(int x, int y, int z);
		tribc_pkg::in_t p;
		p.point_x = x[tribc_pkg::CB-1:0];
		p.point_y = y[tribc_pkg::CB-1:0];
		p.point_z = z[tribc_pkg::CB-1:0];
		return p;
	endfunction

	function automatic tribc_pkg::out_t mk_res(int w0, int w1, int w2, bit ins, bit dg);
		tribc_pkg::out_t o;
		o.weight_v0 = w0[tribc_pkg::WB-1:0];
		o.weight_v1 = w1[tribc_pkg::WB-1:0];
		o.weight_v2 = w2[tribc_pkg::WB-1:0];
		o.inside_res = ins;
		o.degenerate = dg;
		return o;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (weights_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [35:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tribc_pkg::REG_TOL)
			tol_q = val[7:0];
		else begin
			vx[idx] = $signed(val[11:0]);
			vy[idx] = $signed(val[23:12]);
			vz[idx] = $signed(val[35:24]);
		end
	endtask

	task automatic set_triangle(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz, int tol);
		logic [35:0] hi;
		hi = 36'({$urandom, $urandom});
		wait_drained();
		write_reg(tribc_pkg::REG_V0, {az[11:0], ay[11:0], ax[11:0]});
		write_reg(tribc_pkg::REG_V1, {bz[11:0], by[11:0], bx[11:0]});
		write_reg(tribc_pkg::REG_V2, {cz[11:0], cy[11:0], cx[11:0]});
		// upper bits of the tolerance word must be ignored
		write_reg(tribc_pkg::REG_TOL, {hi[35:8], tol[7:0]});
	endtask

	task automatic send(tribc_pkg::in_t pt, bit typed, tribc_pkg::out_t res);
		int gap;
		if ($urandom_range(0, 19) == 0)
			burst = ~burst;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pt;
		do @(posedge clk); while (!in_ready);
		weights_q.push_back(typed ? res : predict_weights(pt));
	endtask

	task automatic random_point();
		int a, b, sel, x, y, z;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			a = $urandom_range(0, 320);
			b = $urandom_range(0, 320 - a);
			x = clamp(vx[0] + (a * (vx[1]-vx[0]) + b * (vx[2]-vx[0])) / 256);
			y = clamp(vy[0] + (a * (vy[1]-vy[0]) + b * (vy[2]-vy[0])) / 256);
			z = clamp(vz[0] + (a * (vz[1]-vz[0]) + b * (vz[2]-vz[0])) / 256);
			if (sel == 5)
				z = clamp(z + $urandom_range(0, 6) - 3);
		end else if (sel < 8) begin
			a = $urandom_range(0, 2);
			x = vx[a]; y = vy[a]; z = vz[a];
		end else begin
			x = $urandom_range(0, 4095) - 2048;
			y = $urandom_range(0, 4095) - 2048;
			z = $urandom_range(0, 4095) - 2048;
		end
		send(mk_pt(x, y, z), 1'b0, '0);
	endtask

	task automatic random_phase(int n, int span);
		int c[9];
		foreach (c[i])
			c[i] = $urandom_range(0, 2 * span) - span;
		set_triangle(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8],
			$urandom_range(0, 255));
		for (int i = 0; i < n; i++)
			random_point();
	endtask

	row_t dir_rows[12];

	initial begin
		dir_rows[0] = '{mk_pt(0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1)};
		dir_rows[1] = '{mk_pt(-2048, -2048, -2048), 1'b1, mk_res(0, 0, 0, 0, 1)};
		dir_rows[2] = '{mk_pt(2047, 2047, 2047), 1'b1, mk_res(0, 0, 0, 0, 1)};
		dir_rows[3] = '{mk_pt(0, 0, 0), 1'b1, mk_res(65536, 0, 0, 1, 0)};
		dir_rows[4] = '{mk_pt(1024, 0, 0), 1'b1, mk_res(0, 65536, 0, 1, 0)};
		dir_rows[5] = '{mk_pt(0, 1024, 0), 1'b1, mk_res(0, 0, 65536, 1, 0)};
		dir_rows[6] = '{mk_pt(300, 300, 0), 1'b0, '0};
		dir_rows[7] = '{mk_pt(512, 512, 0), 1'b0, '0};
		dir_rows[8] = '{mk_pt(100, 100, 50), 1'b0, '0};
		dir_rows[9] = '{mk_pt(2047, 2047, 2047), 1'b0, '0};
		dir_rows[10] = '{mk_pt(-2048, -2048, -2048), 1'b0, '0};
		dir_rows[11] = '{mk_pt(2047, 0, 0), 1'b0, '0};
		vx = '{0, 0, 0}; vy = '{0, 0, 0}; vz = '{0, 0, 0};
		tol_q = 4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (i == 3)
				set_triangle(0, 0, 0, 1024, 0, 0, 0, 1024, 0, 4);
			send(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].res);
		end
		// extreme vertices, widest tolerance
		set_triangle(-2048, -2048, -2048, 2047, -2048, 2047, -2048, 2047, 2047, 255);
		for (int i = 0; i < 80; i++)
			random_point();
		// zero tolerance
		set_triangle(-1500, -1000, 7, 1800, -900, 7, 100, 1900, 7, 0);
		for (int i = 0; i < 80; i++) begin
			if (i == 40)
				wait_drained();
			random_point();
		end
		// collinear, degenerate
		set_triangle(-100, -100, -100, 200, 200, 200, 500, 500, 500, 4);
		for (int i = 0; i < 20; i++)
			random_point();
		random_phase(90, 2047);
		random_phase(90, 300);
		random_phase(60, 6);
		random_phase(110, 1200);
		wait_drained();
		repeat (60) @(posedge clk);
		if (!failed)
			$display("PASS triangle_barycentric_test_top");
		else
			$display("FAIL triangle_barycentric_test_top");
		$finish;
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (weights_q.size() == 0) begin
					failed = 1'b1;
					$display("%0t: unexpected transaction, actual %p", $time, out_data);
				end else begin
					tribc_pkg::out_t e;
					e = weights_q.pop_front();
					if (e.weight_v0 !== out_data.weight_v0 ||
						e.weight_v1 !== out_data.weight_v1 ||
						e.weight_v2 !== out_data.weight_v2 ||
						e.inside_res !== out_data.inside_res ||
						e.degenerate !== out_data.degenerate) begin
						failed = 1'b1;
						$display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
					end
				end
				n = burst ? 0 : $urandom_range(0, 5);
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
			end else if (arst_n)
				out_ready <= 1'b1;
		end
	end

	initial begin
		#20ms;
		$display("FAIL triangle_barycentric_test_top");
		$finish;
	end
endmodule
`default_nettype wire

// ----- triangle_barycentric_test_top.f -----
hw/rtl/tribc_pkg.sv
hw/rtl/tribc_sqrt_cell.sv
hw/rtl/tribc_div_cell.sv
hw/rtl/triangle_barycentric_test_top.sv
hw/rtl/tribc_checker.sv
sim/tb_triangle_barycentric_test_top.sv
